// ----- src/dwsd_pkg.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// dwsd_pkg
// Shared commands, status codes and stream widths of the slot dispatcher.
// -----------------------------------------------------------------------------
package dwsd_pkg;

  // field widths
  localparam int CMD_W  = 2;
  localparam int ID_W   = 6;
  localparam int TAG_W  = 32;
  localparam int STAT_W = 3;

  // stream word widths (padded to whole bytes)
  localparam int S_TDATA_W = 72;
  localparam int M_FIELD_W = STAT_W + ID_W + 2 * TAG_W;
  localparam int M_TDATA_W = 80;

  // commands
  localparam logic [CMD_W-1:0] CMD_ALLOC    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MARK     = 2'd2;
  localparam logic [CMD_W-1:0] CMD_DISPATCH = 2'd3;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
  localparam logic [STAT_W-1:0] ST_NO_FREE    = 3'd1;
  localparam logic [STAT_W-1:0] ST_ILLEGAL_ID = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOT_ALLOC  = 3'd3;
  localparam logic [STAT_W-1:0] ST_PENDING    = 3'd4;
  localparam logic [STAT_W-1:0] ST_NOTHING    = 3'd5;

  // tag pair as held in the tag RAM
  typedef struct packed {
    logic [TAG_W-1:0] context_tag;
    logic [TAG_W-1:0] handler_tag;
  } tag_pair_t;

endpackage

// ----- src/dwsd_ram.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// dwsd_ram
// Generic single-write, single-read RAM with registered read data.
// -----------------------------------------------------------------------------
module dwsd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/dwsd_pick.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// dwsd_pick
// Shared lowest-set-bit finder: used for free-slot search and dispatch scan.
// -----------------------------------------------------------------------------
module dwsd_pick #(
  parameter int W = 32
) (
  input  logic [W-1:0]         vec,
  output logic                 found,
  output logic [$clog2(W)-1:0] idx,
  output logic [W-1:0]         rest
);

  // priority encode, lowest index wins
  always_comb begin
    idx = '0;
    for (int i = W - 1; i >= 0; i--) begin
      if (vec[i]) begin
        idx = ($clog2(W))'(i);
      end
    end
  end

  assign found = |vec;
  // vector with the chosen bit removed
  assign rest  = vec & (vec - W'(1));

endmodule

// ----- src/deferred_work_slot_dispatcher.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// deferred_work_slot_dispatcher
// Slot allocator with pending bitmap and lowest-first dispatch of tag pairs.
// -----------------------------------------------------------------------------
//  channel | dir | handshake        | word
//  s_*     | in  | s_tvalid/tready  | cmd, slot_id, handler_tag, context_tag
//  m_*     | out | m_tvalid/tready  | status, result_slot, tags; tlast = last_of_run
//
//  Allocate, free, mark and an empty dispatch: the result word is registered and
//  shows in the next cycle after acceptance. A dispatch with N pending slots gives
//  N words, each by S_RD (pick, registered tag RAM read), then S_OUT (output load,
//  which waits while the output is blocked). s_tready is low while a dispatch runs
//  and while an unconsumed result blocks the output register. Reset clears both
//  bitmaps; the tag RAM is not cleared.
module deferred_work_slot_dispatcher
  import dwsd_pkg::*;
#(
  parameter int NUM_SLOTS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // [1:0] cmd, [7:2] slot_id, [39:8] handler_tag, [71:40] context_tag
  input  logic [S_TDATA_W-1:0] s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // [2:0] status, [8:3] result_slot, [40:9] out_handler, [72:41] out_context
  output logic [M_TDATA_W-1:0] m_tdata,
  output logic                 m_tlast
);

  localparam int IDX_W = $clog2(NUM_SLOTS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  // input fields
  logic [CMD_W-1:0] cmd;
  logic [ID_W-1:0]  slot_id;
  tag_pair_t        in_tags;

  assign cmd                 = s_tdata[1:0];
  assign slot_id             = s_tdata[7:2];
  assign in_tags.handler_tag = s_tdata[39:8];
  assign in_tags.context_tag = s_tdata[71:40];

  // state
  logic [1:0]           state, state_next;
  logic [NUM_SLOTS-1:0] alloc_map, alloc_map_next;
  logic [NUM_SLOTS-1:0] pend_map, pend_map_next;
  logic [NUM_SLOTS-1:0] snap, snap_next;
  logic [IDX_W-1:0]     cur_slot, cur_slot_next;
  logic                 cur_last, cur_last_next;

  // output register
  logic              m_valid_next;
  logic              out_load;
  logic [STAT_W-1:0] out_status, out_status_next;
  logic [ID_W-1:0]   out_slot, out_slot_next;
  tag_pair_t         out_tags, out_tags_next;
  logic              out_last, out_last_next;

  // shared picker
  logic [NUM_SLOTS-1:0] pick_vec, pick_rest;
  logic                 pick_found;
  logic [IDX_W-1:0]     pick_idx;

  // tag RAM
  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_raddr;
  tag_pair_t        ram_rdata;

  logic             out_free, s_fire;
  logic             id_bad;
  logic [IDX_W-1:0] id_idx;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE) && out_free;
  assign s_fire   = s_tvalid && s_tready;
  assign id_bad   = {1'b0, slot_id} >= (ID_W + 1)'(NUM_SLOTS);
  assign id_idx   = slot_id[IDX_W-1:0];

  // picker looks at free slots when idle, at the snapshot during dispatch
  assign pick_vec = (state == S_IDLE) ? ~alloc_map : snap;

  dwsd_pick #(
    .W (NUM_SLOTS)
  ) u_pick (
    .vec   (pick_vec),
    .found (pick_found),
    .idx   (pick_idx),
    .rest  (pick_rest)
  );

  dwsd_ram #(
    .WIDTH ($bits(tag_pair_t)),
    .DEPTH (NUM_SLOTS)
  ) u_tags (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pick_idx),
    .wdata (in_tags),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sequencer
  always_comb begin
    state_next      = state;
    alloc_map_next  = alloc_map;
    pend_map_next   = pend_map;
    snap_next       = snap;
    cur_slot_next   = cur_slot;
    cur_last_next   = cur_last;
    out_load        = 1'b0;
    out_status_next = ST_OK;
    out_slot_next   = '0;
    out_tags_next   = '0;
    out_last_next   = 1'b1;
    ram_we          = 1'b0;
    ram_re          = 1'b0;
    ram_raddr       = pick_idx;

    case (state)
      S_IDLE: begin
        if (s_fire) begin
          case (cmd)
            CMD_ALLOC: begin
              out_load = 1'b1;
              if (!pick_found) begin
                out_status_next = ST_NO_FREE;
              end else begin
                alloc_map_next[pick_idx] = 1'b1;
                ram_we                   = 1'b1;
                out_slot_next            = ID_W'(pick_idx);
              end
            end
            CMD_FREE, CMD_MARK: begin
              out_load = 1'b1;
              if (id_bad) begin
                out_status_next = ST_ILLEGAL_ID;
              end else if (!alloc_map[id_idx]) begin
                out_status_next = ST_NOT_ALLOC;
              end else if (cmd == CMD_FREE) begin
                if (pend_map[id_idx]) begin
                  out_status_next = ST_PENDING;
                end else begin
                  alloc_map_next[id_idx] = 1'b0;
                end
              end else begin
                pend_map_next[id_idx] = 1'b1;
              end
            end
            default: begin
              // dispatch: snapshot and clear the pending map
              pend_map_next = '0;
              if (pend_map == '0) begin
                out_load        = 1'b1;
                out_status_next = ST_NOTHING;
              end else begin
                snap_next  = pend_map;
                state_next = S_RD;
              end
            end
          endcase
        end
      end
      S_RD: begin
        // take lowest pending slot, start its tag read
        ram_re        = 1'b1;
        cur_slot_next = pick_idx;
        cur_last_next = (pick_rest == '0);
        snap_next     = pick_rest;
        state_next    = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_slot_next = ID_W'(cur_slot);
          out_tags_next = ram_rdata;
          out_last_next = cur_last;
          state_next    = cur_last ? S_IDLE : S_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign m_valid_next = out_load ? 1'b1 : (m_tvalid && !m_tready);

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      alloc_map <= '0;
      pend_map  <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      state     <= state_next;
      alloc_map <= alloc_map_next;
      pend_map  <= pend_map_next;
      m_tvalid  <= m_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    snap     <= snap_next;
    cur_slot <= cur_slot_next;
    cur_last <= cur_last_next;
    if (out_load) begin
      out_status <= out_status_next;
      out_slot   <= out_slot_next;
      out_tags   <= out_tags_next;
      out_last   <= out_last_next;
    end
  end

  // output word
  assign m_tdata = {(M_TDATA_W - M_FIELD_W)'(0), out_tags.context_tag,
                    out_tags.handler_tag, out_slot, out_status};
  assign m_tlast = out_last;

endmodule
